// ----- hw/rtl/servo_pulse_from_can_command_core_macros.svh -----
// assertion macros shared by the servo pulse checker
`ifndef SERVO_PULSE_FROM_CAN_COMMAND_CORE_MACROS_SVH
`define SERVO_PULSE_FROM_CAN_COMMAND_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define SPC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define SPC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// delayed implication, off during reset
`define SPC_ASSERT_DLY2(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error(msg);

// next-cycle implication that also checks the reset itself
`define SPC_ASSERT_RST(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/spc_pkg.sv -----
// types and constants of the servo pulse generator
`default_nettype none

package spc_pkg;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_NODE_ADDRESS = 2'd0,
        CFG_PULSE_CENTER = 2'd1,
        CFG_PULSE_PERIOD = 2'd2
    } t_cfg_index;

    // request kinds
    typedef enum logic {
        REQ_TICK  = 1'b0,
        REQ_FRAME = 1'b1
    } t_req_type;

    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [10:0] NODE_RESET   = 11'd0;
    localparam logic [15:0] CENTER_RESET = 16'd1500;
    localparam logic [15:0] PERIOD_RESET = 16'd20000;

    // magnitude / 45 as (mag * 46604) >> 21, exact for every 15-bit magnitude
    localparam logic [15:0] STEP_MULT  = 16'd46604;
    localparam int unsigned STEP_SHIFT = 21;
    localparam int unsigned MAG_W      = 15;
    localparam int unsigned PROD_W     = MAG_W + 16;
    localparam int unsigned QUO_W      = 10;

    localparam logic [QUO_W-1:0] OFFSET_LIMIT = 10'd700;
    localparam logic [7:0]       MAG_HIGH_MASK = 8'b0111_1111;
    localparam int unsigned      SIGN_BIT      = 7;

    typedef struct packed {
        logic        req_type;
        logic [10:0] frame_id;
        logic [7:0]  data_low;
        logic [7:0]  data_high;
    } t_in_word;

    typedef struct packed {
        logic        pin_level;
        logic [15:0] commanded_width;
    } t_out_word;

    typedef struct packed {
        logic [10:0] node_address;
        logic [15:0] pulse_center;
        logic [15:0] pulse_period;
    } t_cfg;

endpackage

`default_nettype wire

// ----- hw/rtl/spc_cmd.sv -----
// frame decode: scaled, saturated offset around the pulse center
`default_nettype none

module spc_cmd (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_frame_en,
    input  wire spc_pkg::t_in_word i_word,
    input  wire spc_pkg::t_cfg   i_cfg,
    output logic [15:0]          o_width_command,
    output logic [15:0]          o_width_next
);
    import spc_pkg::*;

    logic [15:0]       r_width;
    logic [15:0]       n_width;
    logic              match;
    logic [MAG_W-1:0]  mag;
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  quo;
    logic [QUO_W-1:0]  offset;
    logic [15:0]       offset_ext;
    logic [15:0]       width_calc;

    assign match = i_frame_en && (i_word.frame_id == i_cfg.node_address);
    assign mag   = {i_word.data_high[6:0] & MAG_HIGH_MASK[6:0], i_word.data_low};

    // reciprocal multiply replaces the divide by 45
    assign prod   = {16'b0, mag} * {{(PROD_W-16){1'b0}}, STEP_MULT};
    assign quo    = prod[STEP_SHIFT +: QUO_W];
    assign offset = (quo > OFFSET_LIMIT) ? OFFSET_LIMIT : quo;
    assign offset_ext = {{(16-QUO_W){1'b0}}, offset};

    // negative zero lands on the center as well
    assign width_calc = i_word.data_high[SIGN_BIT] ? (i_cfg.pulse_center - offset_ext)
                                                   : (i_cfg.pulse_center + offset_ext);

    assign n_width = match ? width_calc : r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= CENTER_RESET;
        end else begin
            r_width <= n_width;
        end
    end

    assign o_width_command = r_width;
    assign o_width_next    = n_width;

endmodule

`default_nettype wire

// ----- hw/rtl/spc_period.sv -----
// period counter, width latch and pin level
`default_nettype none

module spc_period #(
    parameter int unsigned TICK_WIDTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_tick_en,
    input  wire logic [15:0]   i_width_command,
    input  wire spc_pkg::t_cfg i_cfg,
    output logic               o_pin_next
);
    import spc_pkg::*;

    localparam int unsigned CMP_W = (TICK_WIDTH > 16) ? TICK_WIDTH : 16;

    logic [TICK_WIDTH-1:0] r_count;
    logic [TICK_WIDTH-1:0] n_count;
    logic [15:0]           r_latched;
    logic [15:0]           n_latched;
    logic                  r_pin;
    logic                  n_pin;
    logic                  cnt_zero;
    logic                  pin_mid;
    logic [TICK_WIDTH-1:0] count_inc;
    logic                  wrap;

    assign cnt_zero  = (r_count == '0);
    assign count_inc = r_count + {{(TICK_WIDTH-1){1'b0}}, 1'b1};

    // zero period means the counter runs its full range
    assign wrap = (i_cfg.pulse_period != 16'd0)
               && (CMP_W'(count_inc) >= CMP_W'(i_cfg.pulse_period));

    always_comb begin
        n_count   = r_count;
        n_latched = r_latched;
        n_pin     = r_pin;
        pin_mid   = r_pin;
        if (i_tick_en) begin
            if (cnt_zero) begin
                n_latched = i_width_command;
                pin_mid   = 1'b0;
            end
            n_pin   = (CMP_W'(r_count) >= CMP_W'(n_latched)) ? 1'b1 : pin_mid;
            n_count = wrap ? '0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_latched <= CENTER_RESET;
            r_pin     <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_latched <= n_latched;
            r_pin     <= n_pin;
        end
    end

    assign o_pin_next = n_pin;

endmodule

`default_nettype wire

// ----- hw/rtl/servo_pulse_from_can_command_core.sv -----
// servo pulse generator top level: handshake stages, config registers, datapath
// pipeline: two register stages, the input register and the result register
// throughput: one word per cycle, ticks and frames alike, unless the output stalls
// the single datapath pass (one 15x16 multiply for frames, two compares for ticks) sets it
// reset: synchronous active low, counter zero, pin low, widths at the 1500 tick center
// config after reset: node address 0, center 1500, period 20000
`default_nettype none

module servo_pulse_from_can_command_core #(
    parameter int unsigned TICK_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // input channel
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire spc_pkg::t_in_word              i_in_word,
    // output channel
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output spc_pkg::t_out_word                  o_out_word,
    // configuration writes
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_index,
    input  wire logic [spc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import spc_pkg::*;

    // configuration registers
    t_cfg      r_cfg;

    // input register stage
    logic      r_in_valid;
    t_in_word  r_in_word;

    // result register stage
    logic      r_out_valid;
    t_out_word r_out_word;

    logic        advance;
    logic        tick_en;
    logic        frame_en;
    logic [15:0] width_command;
    logic [15:0] width_next;
    logic        pin_next;

    // the input word moves on whenever the result register is free or being drained
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    assign tick_en  = advance && (r_in_word.req_type == REQ_TICK);
    assign frame_en = advance && (r_in_word.req_type == REQ_FRAME);

    // frame path: updates the commanded width on an address match
    spc_cmd u_cmd (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_frame_en      (frame_en),
        .i_word          (r_in_word),
        .i_cfg           (r_cfg),
        .o_width_command (width_command),
        .o_width_next    (width_next)
    );

    // tick path: frames never move the counter
    spc_period #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_period (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tick_en       (tick_en),
        .i_width_command (width_command),
        .i_cfg           (r_cfg),
        .o_pin_next      (pin_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_address <= NODE_RESET;
            r_cfg.pulse_center <= CENTER_RESET;
            r_cfg.pulse_period <= PERIOD_RESET;
            r_in_valid         <= 1'b0;
            r_out_valid        <= 1'b0;
        end else begin
            // indexes past the register list are dropped
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_NODE_ADDRESS: r_cfg.node_address <= i_cfg_data[10:0];
                    CFG_PULSE_CENTER: r_cfg.pulse_center <= i_cfg_data;
                    CFG_PULSE_PERIOD: r_cfg.pulse_period <= i_cfg_data;
                    default: ;
                endcase
            end

            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end

        // payload, no reset needed
        if (i_in_valid && !o_in_stall) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word.pin_level       <= pin_next;
            r_out_word.commanded_width <= width_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ----- hw/rtl/spc_checker.sv -----
// port-level checks for the servo pulse generator, bound to the top level
`default_nettype none

`include "servo_pulse_from_can_command_core_macros.svh"

module spc_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire spc_pkg::t_out_word o_out_word
);
    import spc_pkg::*;

    // a held result word keeps its value
    `SPC_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "output word changed while stalled")

    // input backpressure only comes from a full, stalled output
    `SPC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "input stalled without output backpressure")

    // after every accepted word the output valid is expected to be showing
    `SPC_ASSERT_DLY2(a_result_due, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_out_valid, "no result two cycles after accept")

    // reset empties both stages
    `SPC_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n, !o_out_valid && !o_in_stall, "pipeline not empty after reset")

endmodule

bind servo_pulse_from_can_command_core spc_checker u_spc_checker (.*);

`default_nettype wire
